### hdl/gha_pkg.sv
// gha_pkg: shared widths, operation and status codes, result word type
// for the generational handle allocator; depends on nothing
package gha_pkg;

	localparam int DEF_SLOTS = 1024;

	localparam int MODE_W    = 2;
	localparam int IN_IDX_W  = 10;
	localparam int GEN_W     = 16;
	localparam int STATUS_W  = 2;
	localparam int OUT_IDX_W = 11;

	localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NEXT    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_END   = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [OUT_IDX_W-1:0] out_index;
		logic [GEN_W-1:0]     out_gen;
	} result_t;

endpackage

### hdl/gha_mem.sv
// gha_mem: slot table memory, one write port and one read port with
// registered read data; standalone, no package needed
module gha_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 27,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hdl/gha_ctrl.sv
// gha_ctrl: command sequencer, free list head and high-water mark, and the
// read-modify-write of the slot table; depends on gha_pkg
module gha_ctrl #(
	parameter int SLOTS = gha_pkg::DEF_SLOTS,
	localparam int IW   = $clog2(SLOTS),
	localparam int HW_W = $clog2(SLOTS + 1),
	localparam int EW   = 1 + gha_pkg::GEN_W + IW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [gha_pkg::MODE_W-1:0]    mode,
	input  logic [gha_pkg::IN_IDX_W-1:0]  slot_index,
	input  logic [gha_pkg::GEN_W-1:0]     slot_gen,
	output logic                          done,
	output gha_pkg::result_t              result,
	output logic                          mem_we,
	output logic [IW-1:0]                 mem_waddr,
	output logic [EW-1:0]                 mem_wdata,
	output logic [IW-1:0]                 mem_raddr,
	input  logic [EW-1:0]                 mem_rdata
);

	// pointer wide enough for slot_index + 1 and for the high-water mark
	localparam int PW = (HW_W > gha_pkg::OUT_IDX_W) ? HW_W : gha_pkg::OUT_IDX_W;
	localparam int GW = gha_pkg::GEN_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	logic [1:0]      state_q;
	logic            done_q;
	logic [IW-1:0]   free_head_q;
	logic [HW_W-1:0] hw_q;

	logic [gha_pkg::MODE_W-1:0] mode_s1;
	logic [GW-1:0]              gen_s1;
	logic [PW-1:0]              ptr_s1;
	logic                       valid_s1;
	logic                       full_s1;
	logic                       from_list_s1;
	gha_pkg::result_t           result_q;

	logic          accept;
	logic [PW-1:0] ptr_d;
	logic          full_d;
	logic          from_list_d;
	logic [PW-1:0] ptr_next;
	logic [PW-1:0] hw_ext;

	logic            r_alive;
	logic [GW-1:0]   r_gen;
	logic [IW-1:0]   r_link;
	logic [GW-1:0]   gen_inc;
	logic            live;
	logic            fire;
	gha_pkg::result_t res_d;
	logic            scan_more;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign result   = result_q;
	assign hw_ext   = PW'(hw_q);
	assign ptr_next = ptr_s1 + PW'(1);

	// address of the entry an accepted command needs
	always_comb begin
		ptr_d       = PW'(slot_index);
		full_d      = 1'b0;
		from_list_d = 1'b0;
		case (mode)
			gha_pkg::MODE_CREATE: begin
				if (free_head_q != '0) begin
					ptr_d       = PW'(free_head_q);
					from_list_d = 1'b1;
				end else begin
					ptr_d  = hw_ext;
					full_d = (hw_q == HW_W'(SLOTS));
				end
			end
			gha_pkg::MODE_NEXT: ptr_d = PW'(slot_index) + PW'(1);
			default: ptr_d = PW'(slot_index);
		endcase
	end

	assign scan_more = (state_q == S_SCAN) && valid_s1 && !r_alive;
	assign mem_raddr = scan_more ? ptr_next[IW-1:0] : ptr_d[IW-1:0];

	// the reserved slot and entries at or above the high-water mark were never
	// written: their alive flag and generation read as zero
	assign r_alive = valid_s1 && mem_rdata[EW-1];
	assign r_gen   = valid_s1 ? mem_rdata[IW +: GW] : '0;
	assign r_link  = mem_rdata[IW-1:0];
	assign gen_inc = r_gen + GW'(1);
	assign live    = r_alive && (r_gen == gen_s1);
	assign mem_waddr = ptr_s1[IW-1:0];

	always_comb begin
		fire      = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = {r_alive, r_gen, r_link};
		res_d     = '{status: gha_pkg::ST_END, out_index: hw_ext[gha_pkg::OUT_IDX_W-1:0],
			out_gen: '0};
		case (state_q)
			S_EXEC: begin
				fire = 1'b1;
				case (mode_s1)
					gha_pkg::MODE_CREATE: begin
						if (full_s1) begin
							res_d = '{status: gha_pkg::ST_FULL, out_index: '0, out_gen: '0};
						end else begin
							res_d = '{status: gha_pkg::ST_OK,
								out_index: ptr_s1[gha_pkg::OUT_IDX_W-1:0], out_gen: gen_inc};
							mem_we    = 1'b1;
							mem_wdata = {1'b1, gen_inc, r_link};
						end
					end
					gha_pkg::MODE_DESTROY: begin
						if (live) begin
							res_d = '{status: gha_pkg::ST_OK,
								out_index: ptr_s1[gha_pkg::OUT_IDX_W-1:0], out_gen: gen_s1};
							mem_we    = 1'b1;
							mem_wdata = {1'b0, r_gen, free_head_q};
						end else begin
							res_d = '{status: gha_pkg::ST_STALE,
								out_index: ptr_s1[gha_pkg::OUT_IDX_W-1:0], out_gen: '0};
						end
					end
					gha_pkg::MODE_CHECK: begin
						if (live) begin
							res_d = '{status: gha_pkg::ST_OK,
								out_index: ptr_s1[gha_pkg::OUT_IDX_W-1:0], out_gen: r_gen};
						end else begin
							res_d = '{status: gha_pkg::ST_STALE,
								out_index: ptr_s1[gha_pkg::OUT_IDX_W-1:0], out_gen: '0};
						end
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				if (!valid_s1) begin
					fire = 1'b1;
				end else if (r_alive) begin
					fire  = 1'b1;
					res_d = '{status: gha_pkg::ST_OK,
						out_index: ptr_s1[gha_pkg::OUT_IDX_W-1:0], out_gen: r_gen};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			free_head_q <= '0;
			hw_q        <= HW_W'(1);
		end else begin
			done_q <= fire;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (mode == gha_pkg::MODE_NEXT) ? S_SCAN : S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					if (mode_s1 == gha_pkg::MODE_CREATE && !full_s1) begin
						if (from_list_s1) begin
							free_head_q <= r_link;
						end else begin
							hw_q <= hw_q + HW_W'(1);
						end
					end
					if (mode_s1 == gha_pkg::MODE_DESTROY && live) begin
						free_head_q <= ptr_s1[IW-1:0];
					end
				end
				S_SCAN: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1      <= mode;
			gen_s1       <= slot_gen;
			ptr_s1       <= ptr_d;
			valid_s1     <= (ptr_d < hw_ext) && (ptr_d != '0);
			full_s1      <= full_d;
			from_list_s1 <= from_list_d;
		end else if (scan_more) begin
			ptr_s1   <= ptr_next;
			valid_s1 <= (ptr_next < hw_ext);
		end
		if (fire) begin
			result_q <= res_d;
		end
	end

endmodule

### hdl/generational_handle_allocator_top.sv
// order: create, destroy and check read their slot entry in the EXEC state and register
// done from it; next steps through the entries in the SCAN state, past each dead slot
// below the high-water mark, until it finds a live one or reaches the mark
// busy: a new word is taken only in the idle state, once the last one is done
// the receiver cannot stall: each word is shown for exactly one cycle with done
// reset: arst_n clears the sequencer, free list head and high-water mark; the table needs
// no clearing pass, slot 0 and entries at or above the high-water mark read as never used
module generational_handle_allocator_top #(
	parameter int SLOTS = gha_pkg::DEF_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [gha_pkg::MODE_W-1:0]    mode,
	input  logic [gha_pkg::IN_IDX_W-1:0]  slot_index,
	input  logic [gha_pkg::GEN_W-1:0]     slot_gen,
	output logic                          done,
	output logic [gha_pkg::STATUS_W-1:0]  status,
	output logic [gha_pkg::OUT_IDX_W-1:0] out_index,
	output logic [gha_pkg::GEN_W-1:0]     out_gen
);

	localparam int IW = $clog2(SLOTS);
	localparam int EW = 1 + gha_pkg::GEN_W + IW;

	gha_pkg::result_t result;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic [EW-1:0]    mem_wdata;
	logic [IW-1:0]    mem_raddr;
	logic [EW-1:0]    mem_rdata;

	gha_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.slot_index (slot_index),
		.slot_gen   (slot_gen),
		.done       (done),
		.result     (result),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	gha_mem #(.DEPTH(SLOTS), .WIDTH(EW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign status    = result.status;
	assign out_index = result.out_index;
	assign out_gen   = result.out_gen;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted word did not start work");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == gha_pkg::ST_FULL) |-> (out_index == '0 && out_gen == '0))
		else $error("pool full word carries a handle");

	a_end_gen: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == gha_pkg::ST_END || status == gha_pkg::ST_STALE)) |-> out_gen == '0)
		else $error("end or stale word carries a generation");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for generational_handle_allocator_top; a directed table whose
// typed rows carry their expected words, and random phases checked against a behavioral slot table
// depends on gha_pkg and the allocator rtl
module tb;

	localparam int NSLOT       = gha_pkg::DEF_SLOTS;
	localparam int STALL_LIMIT = 20000;
	localparam int N_DIR       = 24;

	typedef struct packed {
		logic [gha_pkg::MODE_W-1:0]   m;
		logic [gha_pkg::IN_IDX_W-1:0] idx;
		logic [gha_pkg::GEN_W-1:0]    g;
		logic                         typed;
		gha_pkg::result_t             r;
	} dir_row_t;

	// rows with typed cleared are checked against the slot table only
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		{gha_pkg::MODE_CHECK,   10'd0,    16'd0,    1'b1, gha_pkg::ST_STALE, 11'd0,    16'd0},
		{gha_pkg::MODE_DESTROY, 10'd0,    16'd0,    1'b1, gha_pkg::ST_STALE, 11'd0,    16'd0},
		{gha_pkg::MODE_NEXT,    10'd0,    16'd0,    1'b1, gha_pkg::ST_END,   11'd1,    16'd0},
		{gha_pkg::MODE_NEXT,    10'd1023, 16'hffff, 1'b1, gha_pkg::ST_END,   11'd1,    16'd0},
		{gha_pkg::MODE_CREATE,  10'd0,    16'd0,    1'b1, gha_pkg::ST_OK,    11'd1,    16'd1},
		{gha_pkg::MODE_CREATE,  10'd1023, 16'hffff, 1'b1, gha_pkg::ST_OK,    11'd2,    16'd1},
		{gha_pkg::MODE_CREATE,  10'd0,    16'd0,    1'b1, gha_pkg::ST_OK,    11'd3,    16'd1},
		{gha_pkg::MODE_CHECK,   10'd2,    16'd1,    1'b1, gha_pkg::ST_OK,    11'd2,    16'd1},
		{gha_pkg::MODE_CHECK,   10'd2,    16'hffff, 1'b1, gha_pkg::ST_STALE, 11'd2,    16'd0},
		{gha_pkg::MODE_CHECK,   10'd1023, 16'hffff, 1'b1, gha_pkg::ST_STALE, 11'd1023, 16'd0},
		{gha_pkg::MODE_DESTROY, 10'd2,    16'd1,    1'b1, gha_pkg::ST_OK,    11'd2,    16'd1},
		{gha_pkg::MODE_DESTROY, 10'd2,    16'd1,    1'b1, gha_pkg::ST_STALE, 11'd2,    16'd0},
		{gha_pkg::MODE_NEXT,    10'd0,    16'd0,    1'b1, gha_pkg::ST_OK,    11'd1,    16'd1},
		{gha_pkg::MODE_NEXT,    10'd1,    16'd0,    1'b1, gha_pkg::ST_OK,    11'd3,    16'd1},
		{gha_pkg::MODE_NEXT,    10'd3,    16'd0,    1'b1, gha_pkg::ST_END,   11'd4,    16'd0},
		{gha_pkg::MODE_CREATE,  10'd0,    16'd0,    1'b1, gha_pkg::ST_OK,    11'd2,    16'd2},
		{gha_pkg::MODE_DESTROY, 10'd1,    16'd1,    1'b1, gha_pkg::ST_OK,    11'd1,    16'd1},
		{gha_pkg::MODE_DESTROY, 10'd3,    16'd1,    1'b1, gha_pkg::ST_OK,    11'd3,    16'd1},
		{gha_pkg::MODE_CREATE,  10'd0,    16'd0,    1'b0, gha_pkg::ST_OK,    11'd0,    16'd0},
		{gha_pkg::MODE_CREATE,  10'd0,    16'd0,    1'b0, gha_pkg::ST_OK,    11'd0,    16'd0},
		{gha_pkg::MODE_CREATE,  10'd0,    16'd0,    1'b1, gha_pkg::ST_OK,    11'd4,    16'd1},
		{gha_pkg::MODE_CHECK,   10'd4,    16'd0,    1'b1, gha_pkg::ST_STALE, 11'd4,    16'd0},
		{gha_pkg::MODE_NEXT,    10'd1023, 16'd0,    1'b1, gha_pkg::ST_END,   11'd5,    16'd0},
		{gha_pkg::MODE_NEXT,    10'd2,    16'd0,    1'b1, gha_pkg::ST_OK,    11'd3,    16'd2}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [gha_pkg::MODE_W-1:0]    mode;
	logic [gha_pkg::IN_IDX_W-1:0]  slot_index;
	logic [gha_pkg::GEN_W-1:0]     slot_gen;
	logic                          done;
	logic [gha_pkg::STATUS_W-1:0]  status;
	logic [gha_pkg::OUT_IDX_W-1:0] out_index;
	logic [gha_pkg::GEN_W-1:0]     out_gen;

	// behavioral slot table
	bit                        alive_tab [NSLOT];
	logic [gha_pkg::GEN_W-1:0] gen_tab [NSLOT];
	int                        link_tab [NSLOT];
	int                        free_top;
	int                        hwm;
	int                        live_q [$];
	int                        full_hits;

	gha_pkg::result_t pending_q [$];
	int               mismatches = 0;
	int               stall_cycles = 0;

	generational_handle_allocator_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.slot_index (slot_index),
		.slot_gen   (slot_gen),
		.done       (done),
		.status     (status),
		.out_index  (out_index),
		.out_gen    (out_gen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic gha_pkg::result_t slot_table_step(logic [gha_pkg::MODE_W-1:0] m,
			logic [gha_pkg::IN_IDX_W-1:0] idx, logic [gha_pkg::GEN_W-1:0] g);
		gha_pkg::result_t r;
		int slot;
		bit hit;
		r = '0;
		slot = 0;
		hit = alive_tab[idx] && gen_tab[idx] == g;
		case (m)
		gha_pkg::MODE_CREATE: begin
			if (free_top != 0) begin
				slot = free_top;
				free_top = link_tab[slot];
			end else if (hwm < NSLOT) begin
				slot = hwm;
				hwm++;
			end
			// slot 0 is never handed out, so it marks a full pool here
			if (slot == 0) begin
				r.status = gha_pkg::ST_FULL;
				full_hits++;
			end else begin
				gen_tab[slot] = gen_tab[slot] + 16'd1;
				alive_tab[slot] = 1'b1;
				live_q.push_back(slot);
				r = {gha_pkg::ST_OK, gha_pkg::OUT_IDX_W'(slot), gen_tab[slot]};
			end
		end
		gha_pkg::MODE_DESTROY: begin
			if (hit) begin
				alive_tab[idx] = 1'b0;
				link_tab[idx] = free_top;
				free_top = int'(idx);
				foreach (live_q[k])
					if (live_q[k] == int'(idx)) begin
						live_q.delete(k);
						break;
					end
				r = {gha_pkg::ST_OK, gha_pkg::OUT_IDX_W'(idx), g};
			end else begin
				r = {gha_pkg::ST_STALE, gha_pkg::OUT_IDX_W'(idx), 16'd0};
			end
		end
		gha_pkg::MODE_CHECK: begin
			if (hit)
				r = {gha_pkg::ST_OK, gha_pkg::OUT_IDX_W'(idx), gen_tab[idx]};
			else
				r = {gha_pkg::ST_STALE, gha_pkg::OUT_IDX_W'(idx), 16'd0};
		end
		default: begin
			r = {gha_pkg::ST_END, gha_pkg::OUT_IDX_W'(hwm), 16'd0};
			for (int i = int'(idx) + 1; i < hwm; i++)
				if (alive_tab[i]) begin
					r = {gha_pkg::ST_OK, gha_pkg::OUT_IDX_W'(i), gen_tab[i]};
					break;
				end
		end
		endcase
		return r;
	endfunction

	// drive one word and hold it until the block takes it
	task automatic issue(logic [gha_pkg::MODE_W-1:0] m, logic [gha_pkg::IN_IDX_W-1:0] idx,
			logic [gha_pkg::GEN_W-1:0] g, bit typed, gha_pkg::result_t typed_r);
		gha_pkg::result_t r;
		bit taken;
		start <= 1'b1;
		mode <= m;
		slot_index <= idx;
		slot_gen <= g;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		r = slot_table_step(m, idx, g);
		pending_q.push_back(typed ? typed_r : r);
	endtask

	task automatic sender_gap(int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained;
		start <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	// mostly live handles with random content, the rest stale or random noise
	task automatic random_item(int pct_create);
		int pick;
		int k;
		logic [gha_pkg::MODE_W-1:0] m;
		logic [gha_pkg::IN_IDX_W-1:0] idx;
		logic [gha_pkg::GEN_W-1:0] g;
		idx = 10'($urandom);
		g = 16'($urandom);
		m = gha_pkg::MODE_CREATE;
		if ($urandom_range(99) >= pct_create) begin
			pick = $urandom_range(99);
			m = pick < 40 ? gha_pkg::MODE_DESTROY :
				pick < 70 ? gha_pkg::MODE_CHECK : gha_pkg::MODE_NEXT;
			if (m == gha_pkg::MODE_NEXT) begin
				if ($urandom_range(3) != 0)
					idx = 10'($urandom_range(hwm));
			end else begin
				pick = $urandom_range(99);
				if (pick < 90 && live_q.size() > 0) begin
					k = $urandom_range(live_q.size() - 1);
					idx = 10'(live_q[k]);
					g = gen_tab[live_q[k]];
					if (pick >= 80)
						g = g ^ 16'($urandom_range(65535, 1));
				end else if (pick < 95) begin
					idx = '0;
				end
			end
		end
		issue(m, idx, g, 1'b0, '0);
	endtask

	always @(negedge clk) begin
		gha_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: word with nothing pending: status %0d index %0d gen %0d",
						$time, status, out_index, out_gen);
			end else begin
				want = pending_q.pop_front();
				if (status !== want.status || out_index !== want.out_index ||
						out_gen !== want.out_gen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch: expected status %0d index %0d gen %0d, got %0d %0d %0d",
							$time, want.status, want.out_index, want.out_gen,
							status, out_index, out_gen);
				end
			end
		end
	end

	// counts cycles with no word taken in or handed out
	always @(negedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles = 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles++;
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		mode <= gha_pkg::MODE_CREATE;
		slot_index <= '0;
		slot_gen <= '0;
		foreach (alive_tab[i]) begin
			alive_tab[i] = 1'b0;
			gen_tab[i] = '0;
			link_tab[i] = 0;
		end
		free_top = 0;
		hwm = 1;
		full_hits = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < N_DIR; n++) begin
			issue(DIR_ROWS[n].m, DIR_ROWS[n].idx, DIR_ROWS[n].g, DIR_ROWS[n].typed,
				DIR_ROWS[n].r);
			sender_gap(40);
		end
		wait_drained;

		// back to back, mixed traffic
		repeat (350)
			random_item(45);
		wait_drained;

		// create heavy until the pool has been found full several times
		while (full_hits < 6) begin
			random_item(95);
			sender_gap(60);
		end
		wait_drained;

		// free slots back out of a full pool
		repeat (500) begin
			random_item(30);
			sender_gap(36);
		end
		wait_drained;
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
hdl/gha_pkg.sv
hdl/gha_mem.sv
hdl/gha_ctrl.sv
hdl/generational_handle_allocator_top.sv
verif/tb.sv
